[rtl/core/double_ended_queue_defines.svh]
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// The property holds at every clock edge outside reset.
`define DEQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// When the trigger holds, the property holds at the next clock edge.
`define DEQ_ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

[rtl/core/dq_pkg.sv]
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, operation and status codes, the transfer payload types and the cell control type.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int CAPACITY    = 16;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int DATA_W      = 32;
    localparam int RES_COUNT_W = 5;

    localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [1:0] OP_POP_BACK   = 2'd3;

    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [DATA_W-1:0] value;
    } dq_cmd_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [RES_COUNT_W-1:0]   count;
        logic                     is_empty;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
    } dq_res_t;

    typedef struct packed {
        logic add_head;
        logic add_tail;
        logic take_head;
        logic take_tail;
    } dq_ctrl_t;

endpackage

[rtl/core/double_ended_queue.sv]
// The queue takes one operation per transfer and returns one result per
// operation, in the cycle after the command transfer; a new command is taken in
// every cycle unless a result is still waiting under stall. The words sit
// packed in a row of cells from the front, so front operations shift the row
// and back operations touch only the cell at its end. Results give the state
// after the operation, with both end values 0 when the queue is empty.
// ----------------------------------------------------------------------------
// Double-ended queue top level
// Command and result channels around the cell chain and its control.
// ----------------------------------------------------------------------------
module double_ended_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  dq_pkg::dq_cmd_t cmd,
    output logic            res_valid,
    input  logic            res_stall,
    output dq_pkg::dq_res_t res
);
    import dq_pkg::*;

    `include "double_ended_queue_defines.svh"

    logic                     accept;
    logic                     res_valid_reg;
    logic                     res_valid_next;
    dq_ctrl_t                 ctrl;
    logic [CNT_W-1:0]         count;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]      cell_valid;
    logic [CAPACITY-1:0]      cell_last;
    logic signed [DATA_W-1:0] back_value;

    assign cmd_stall = res_valid_reg && res_stall;
    assign accept    = cmd_valid && !cmd_stall;

    dq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .op     (cmd.op),
        .ctrl   (ctrl),
        .count  (count),
        .status (status)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_data;
        logic                     left_valid;
        logic signed [DATA_W-1:0] right_data;
        logic                     right_valid;

        if (i == 0)
        begin : g_head
            assign left_data  = cmd.value;
            assign left_valid = 1'b1;
        end
        else
        begin : g_body
            assign left_data  = cell_data[i-1];
            assign left_valid = cell_valid[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_data  = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_inner
            assign right_data  = cell_data[i+1];
            assign right_valid = cell_valid[i+1];
        end

        assign cell_last[i] = cell_valid[i] && !right_valid;

        dq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .push_value  (cmd.value),
            .left_data   (left_data),
            .left_valid  (left_valid),
            .right_data  (right_data),
            .right_valid (right_valid),
            .data        (cell_data[i]),
            .valid       (cell_valid[i])
        );
    end

    always_comb
    begin
        back_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            back_value = back_value | (cell_data[i] & {DATA_W{cell_last[i]}});
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid       = res_valid_reg;
    assign res.status      = status;
    assign res.count       = RES_COUNT_W'(count);
    assign res.is_empty    = !cell_valid[0];
    assign res.front_value = cell_valid[0] ? cell_data[0] : '0;
    assign res.back_value  = back_value;

    `DEQ_ASSERT_ALWAYS(a_count_matches_cells,
        $countones(cell_valid) == int'(count), "count disagrees with occupied cells")
    `DEQ_ASSERT_ALWAYS(a_cells_packed,
        (cell_valid & (cell_valid + CAPACITY'(1))) == '0, "occupied cells not packed")
    `DEQ_ASSERT_ALWAYS(a_single_back, $onehot0(cell_last), "more than one back cell")
    `DEQ_ASSERT_NEXT(a_push_front_lands,
        ctrl.add_head, res.front_value == $past(cmd.value), "push front value lost")

endmodule

[rtl/core/dq_cell.sv]
// ----------------------------------------------------------------------------
// Double-ended queue cell
// One slot of the packed chain; shifts with its neighbors on front operations.
// ----------------------------------------------------------------------------
module dq_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dq_pkg::dq_ctrl_t                 ctrl,
    input  logic signed [dq_pkg::DATA_W-1:0] push_value,
    input  logic signed [dq_pkg::DATA_W-1:0] left_data,
    input  logic                             left_valid,
    input  logic signed [dq_pkg::DATA_W-1:0] right_data,
    input  logic                             right_valid,
    output logic signed [dq_pkg::DATA_W-1:0] data,
    output logic                             valid
);
    import dq_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     valid_reg;
    logic                     valid_next;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctrl.add_head)
        begin
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (ctrl.take_head)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (ctrl.add_tail && !valid_reg && left_valid)
        begin
            data_next  = push_value;
            valid_next = 1'b1;
        end
        else if (ctrl.take_tail && valid_reg && !right_valid)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

[rtl/core/dq_ctrl.sv]
// ----------------------------------------------------------------------------
// Double-ended queue control
// Decodes operations, checks full and empty, and keeps the count and status.
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [1:0]                op,
    output dq_pkg::dq_ctrl_t          ctrl,
    output logic [dq_pkg::CNT_W-1:0]  count,
    output logic [1:0]                status
);
    import dq_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic             full;
    logic             empty;

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    always_comb
    begin
        ctrl        = '0;
        count_next  = count_reg;
        status_next = status_reg;
        if (accept)
        begin
            status_next = ST_DONE;
            unique case (op) inside
                OP_PUSH_FRONT, OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = ST_PUSH_FULL;
                    end
                    else
                    begin
                        ctrl.add_head = (op == OP_PUSH_FRONT);
                        ctrl.add_tail = (op == OP_PUSH_BACK);
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                OP_POP_FRONT, OP_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = ST_POP_EMPTY;
                    end
                    else
                    begin
                        ctrl.take_head = (op == OP_POP_FRONT);
                        ctrl.take_tail = (op == OP_POP_BACK);
                        count_next     = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= ST_DONE;
        end
        else
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    assign count  = count_reg;
    assign status = status_reg;

endmodule

[verif/dq_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue result checker
// Watches the command and result channels and keeps its own copy of the
// ring of words. It works out the state after each accepted command and
// compares every accepted result with the oldest view still waiting.
// ----------------------------------------------------------------------------
module dq_result_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  logic            cmd_stall,
    input  dq_pkg::dq_cmd_t cmd,
    input  logic            res_valid,
    input  logic            res_stall,
    input  dq_pkg::dq_res_t res,
    output int              errors,
    output int              outstanding
);
    import dq_pkg::*;

    logic [DATA_W-1:0] words [CAPACITY];
    int                head;
    int                held;
    dq_res_t           queue_views [$];

    function automatic dq_res_t apply_op(input dq_cmd_t c);
        dq_res_t v;
        v = '0;
        v.status = ST_DONE;
        if (c.op == OP_PUSH_FRONT || c.op == OP_PUSH_BACK)
        begin
            if (held == CAPACITY)
            begin
                v.status = ST_PUSH_FULL;
            end
            else
            begin
                if (c.op == OP_PUSH_FRONT)
                begin
                    head = (head + CAPACITY - 1) % CAPACITY;
                    words[head] = c.value;
                end
                else
                begin
                    words[(head + held) % CAPACITY] = c.value;
                end
                held++;
            end
        end
        else if (held == 0)
        begin
            v.status = ST_POP_EMPTY;
        end
        else
        begin
            if (c.op == OP_POP_FRONT)
            begin
                head = (head + 1) % CAPACITY;
            end
            held--;
        end
        v.count = RES_COUNT_W'(held);
        v.is_empty = (held == 0);
        if (held != 0)
        begin
            v.front_value = words[head];
            v.back_value = words[(head + held - 1) % CAPACITY];
        end
        return v;
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
        errors = errors + 1;
    endtask

    task automatic compare_view(input dq_res_t got);
        dq_res_t want;
        if (queue_views.size() == 0)
        begin
            report_mismatch("result without a pending command", '0, DATA_W'(got.count));
            return;
        end
        want = queue_views[0];
        queue_views.delete(0);
        if (got.status !== want.status)
        begin
            report_mismatch("status", DATA_W'(want.status), DATA_W'(got.status));
        end
        if (got.count !== want.count)
        begin
            report_mismatch("count", DATA_W'(want.count), DATA_W'(got.count));
        end
        if (got.is_empty !== want.is_empty)
        begin
            report_mismatch("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
        end
        if (got.front_value !== want.front_value)
        begin
            report_mismatch("front_value", want.front_value, got.front_value);
        end
        if (got.back_value !== want.back_value)
        begin
            report_mismatch("back_value", want.back_value, got.back_value);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head = 0;
            held = 0;
            errors = 0;
            queue_views.delete();
            outstanding <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                compare_view(res);
            end
            if (cmd_valid && !cmd_stall)
            begin
                queue_views.insert(queue_views.size(), apply_op(cmd));
            end
            outstanding <= queue_views.size();
        end
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives a directed sequence through empty, full and pointer wrap, then
// random command runs whose push bias swings the fill level between both
// ends, with random gaps on the command side and random result stalls.
// ----------------------------------------------------------------------------
module tb;
    import dq_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic    clk;
    logic    rst_n;
    logic    cmd_valid;
    logic    cmd_stall;
    dq_cmd_t cmd;
    logic    res_valid;
    logic    res_stall;
    dq_res_t res;
    logic    calm;
    int      errors;
    int      outstanding;
    int      idle_cycles;

    double_ended_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    dq_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            res_stall <= !calm && ($urandom_range(99) < 9);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_op(input logic [1:0] op, input logic [DATA_W-1:0] word);
        if (!calm && $urandom_range(99) < 9)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= dq_cmd_t'{op: op, value: word};
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        logic [DATA_W-1:0] corner_words [4];
        logic [1:0]        op;
        logic [DATA_W-1:0] word;
        int                push_pct;
        int                n;

        corner_words[0] = 32'h8000_0000;
        corner_words[1] = 32'h7fff_ffff;
        corner_words[2] = 32'h0000_0000;
        corner_words[3] = 32'hffff_ffff;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        calm = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pops on an empty queue, then a front push that wraps the pointer.
        send_op(OP_POP_FRONT, 32'h1234_5678);
        send_op(OP_POP_BACK, 32'h8765_4321);
        send_op(OP_PUSH_FRONT, 32'h7fff_ffff);
        send_op(OP_PUSH_BACK, 32'h8000_0000);
        send_op(OP_POP_FRONT, '0);
        send_op(OP_POP_BACK, '0);
        send_op(OP_PUSH_BACK, 32'hffff_ffff);
        send_op(OP_PUSH_FRONT, 32'h0000_0000);
        for (int i = 0; i < CAPACITY - 2; i++)
        begin
            send_op((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, 32'h0101_0101 * (i + 1));
        end
        // The queue is full here, so both pushes must be refused.
        send_op(OP_PUSH_FRONT, 32'hdead_beef);
        send_op(OP_PUSH_BACK, 32'hcafe_f00d);
        send_op(OP_POP_BACK, '0);
        send_op(OP_POP_FRONT, '0);

        for (int seg = 0; seg < 12; seg++)
        begin
            case ($urandom_range(2))
                0: push_pct = 15;
                1: push_pct = 50;
                default: push_pct = 85;
            endcase
            for (int k = 0; k < 40; k++)
            begin
                n = seg * 40 + k;
                calm <= (n >= 150 && n < 270);
                if ($urandom_range(99) < push_pct)
                begin
                    op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                end
                else
                begin
                    op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
                end
                word = ($urandom_range(7) == 0) ? corner_words[$urandom_range(3)] : $urandom;
                send_op(op, word);
            end
        end

        cmd_valid <= 1'b0;
        calm <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/dq_pkg.sv
rtl/core/dq_cell.sv
rtl/core/dq_ctrl.sv
rtl/core/double_ended_queue.sv
verif/dq_result_checker.sv
verif/tb.sv
